### rtl/dttbl_pkg.sv
// ----------------------------------------------------------------------------
// dttbl_pkg
// types, codes and helpers shared by the drift time to radius table
// ----------------------------------------------------------------------------
package dttbl_pkg;

   // item kinds carried on req_tuser
   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_FORWARD = 2'd1;
   localparam logic [1:0] MODE_INVERSE = 2'd2;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_CLAMPED   = 3'd1;
   localparam logic [2:0] ST_EXTRAP    = 3'd2;
   localparam logic [2:0] ST_TOO_SMALL = 3'd3;
   localparam logic [2:0] ST_NO_CONV   = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;
   localparam logic [2:0] ST_ZERO_SEG  = 3'd6;

   // register indexes
   localparam logic [1:0] CSR_UPPER_TIME = 2'd0;
   localparam logic [1:0] CSR_TOLERANCE  = 2'd1;

   localparam logic [14:0] UPPER_TIME_RESET = 15'd12587;
   localparam logic [9:0]  TOLERANCE_RESET  = 10'd1;
   localparam logic signed [15:0] MOST_NEGATIVE = 16'sh8000;

   // divider operand sizes: |dv * dt_query| stays below 2^33
   localparam int PROD_W = 34;
   localparam int DEN_W  = 17;

   typedef struct packed {
      logic signed [15:0] t;
      logic signed [15:0] r;
      logic        [15:0] s;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [14:0] {
      S_IDLE    = 15'b000000000000001,
      S_T0_RD   = 15'b000000000000010,
      S_T0_WAIT = 15'b000000000000100,
      S_F_RD0   = 15'b000000000001000,
      S_F_RDL   = 15'b000000000010000,
      S_F_CHK   = 15'b000000000100000,
      S_F_SCAN  = 15'b000000001000000,
      S_F_HI    = 15'b000000010000000,
      S_F_LO    = 15'b000000100000000,
      S_F_MUL   = 15'b000001000000000,
      S_F_SETUP = 15'b000010000000000,
      S_F_DIV   = 15'b000100000000000,
      S_F_FIN   = 15'b001000000000000,
      S_EVAL    = 15'b010000000000000,
      S_OUT     = 15'b100000000000000
   } state_type;

   // inverse query phases
   typedef enum logic [3:0] {
      PH_LOW    = 4'b0001,
      PH_HIGH   = 4'b0010,
      PH_BISECT = 4'b0100,
      PH_CHECK  = 4'b1000
   } phase_type;

   function automatic logic [15:0] sat16(input logic signed [35:0] x);
      if (x > 36'sd32767) begin
         return 16'h7fff;
      end else if (x < -36'sd32768) begin
         return 16'h8000;
      end
      return x[15:0];
   endfunction

endpackage

### rtl/drift_time_radius_table.sv
// ----------------------------------------------------------------------------
// drift_time_radius_table
// piecewise linear drift time to radius table with bisection inverse
// ----------------------------------------------------------------------------
// Points (time, radius, resolution) are loaded one per transfer into a single
// ram of TABLE_DEPTH entries; each load that is taken gets a response. A
// forward query walks the ram through its single read port: first entry, last
// entry, then a downward scan for the segment (one entry a cycle), two segment
// reads, a multiply and a restoring divider that serves radius and resolution
// together. An inverse query runs the forward sequence for the low bound, the
// high bound and once per bisection step, up to MAX_BISECT_STEPS + 2 forward
// passes. The ram is written only when a load is taken and read only while a
// query is running, so the two never touch the same entry in one cycle. Entries
// above the fill count are never read, so no clearing pass is needed after
// reset.
// ----------------------------------------------------------------------------
module drift_time_radius_table
   import dttbl_pkg::*;
#(
   parameter int TABLE_DEPTH      = 128,
   parameter int MAX_BISECT_STEPS = 51
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // point_time, point_radius, point_resolution, query_time, query_radius
   input  logic [79:0] req_tdata,
   // mode, restart
   input  logic [2:0]  req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // radius, resolution, found_time
   output logic [47:0] rsp_tdata,
   // status, order_warning
   output logic [3:0]  rsp_tuser,
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [14:0] csr_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = $clog2(MAX_BISECT_STEPS + 1);
   localparam int BW = $clog2(PROD_W + 1);

   // request fields
   logic [1:0]         req_mode;
   logic               req_restart;
   logic signed [15:0] req_point_time, req_point_radius, req_query_time, req_query_radius;
   logic [15:0]        req_point_resolution;

   assign req_mode             = req_tuser[1:0];
   assign req_restart          = req_tuser[2];
   assign req_point_time       = req_tdata[15:0];
   assign req_point_radius     = req_tdata[31:16];
   assign req_point_resolution = req_tdata[47:32];
   assign req_query_time       = req_tdata[63:48];
   assign req_query_radius     = req_tdata[79:64];

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   // table bookkeeping and registers
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic signed [15:0] prev_t_ff, prev_t_in, prev_r_ff, prev_r_in;
   logic [14:0]        upper_ff, upper_in;
   logic [9:0]         tol_ff, tol_in;

   // query context
   logic [1:0]         mode_ff, mode_in;
   logic signed [15:0] qt_ff, qt_in;
   logic signed [15:0] qr_ff, qr_in;
   logic signed [17:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [SW-1:0]      step_ff, step_in;

   // entries pulled from the ram
   entry_type          e0_ff, e0_in, el_ff, el_in, elo_ff, elo_in, ehi_ff, ehi_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               anc_hi_ff, anc_hi_in;

   // multiply and divide
   logic signed [PROD_W-1:0] pr_ff, pr_in, ps_ff, ps_in;
   logic [PROD_W-1:0]  nr_ff, nr_in, ns_ff, ns_in;
   logic [DEN_W-1:0]   rr_ff, rr_in, rs_ff, rs_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic               negr_ff, negr_in, negs_ff, negs_in;
   logic [BW-1:0]      bit_ff, bit_in;

   // forward result
   logic [15:0]        fr_ff, fr_in, fs_ff, fs_in;
   logic [2:0]         fst_ff, fst_in;

   // staged result and output register
   logic [15:0]        o_rad_ff, o_rad_in, o_res_ff, o_res_in, o_ft_ff, o_ft_in;
   logic [2:0]         o_st_ff, o_st_in;
   logic               o_warn_ff, o_warn_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [47:0]        rsp_data_ff, rsp_data_in;
   logic [3:0]         rsp_user_ff, rsp_user_in;

   // ram ports
   logic               wr_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   entry_type          wr_entry, rd_entry;

   logic               req_xfer;
   logic [AW-1:0]      last_idx;
   logic [CW-1:0]      load_cnt;
   logic signed [15:0] load_prev_t, load_prev_r;
   logic               load_full;

   // datapath helpers
   logic signed [16:0] dt, tdiff, dvr, dvs;
   logic signed [15:0] tanc;
   entry_type          eanc;
   logic               scan_more, at_or_above_last;
   logic [DEN_W:0]     shr, shs;
   logic [DEN_W:0]     trr, trs;
   logic signed [PROD_W:0] qsr, qss;
   logic signed [35:0] sumr, sums;
   logic signed [16:0] rerr;
   logic [16:0]        rerr_abs;
   logic signed [17:0] mid;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign last_idx   = AW'(cnt_ff - CW'(1));

   // restart empties the table ahead of this point
   assign load_cnt    = req_restart ? '0 : cnt_ff;
   assign load_prev_t = req_restart ? MOST_NEGATIVE : prev_t_ff;
   assign load_prev_r = req_restart ? MOST_NEGATIVE : prev_r_ff;
   assign load_full   = (load_cnt == CW'(TABLE_DEPTH));

   assign wr_en    = req_xfer && (req_mode == MODE_LOAD) && !load_full;
   assign wr_addr  = AW'(load_cnt);
   assign wr_entry = '{t: req_point_time, r: req_point_radius, s: req_point_resolution};

   dttbl_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_addr(rd_addr),
      .rd_data(rd_entry)
   );

   // segment decisions on the word just read
   assign at_or_above_last = (qt_ff >= rd_entry.t);
   assign scan_more        = (idx_ff != '0) && (rd_entry.t > qt_ff);

   always_comb begin
      unique case (state_ff)
         S_F_RDL:  rd_addr = last_idx;
         S_F_CHK:  rd_addr = at_or_above_last ? AW'(last_idx - AW'(1)) : AW'(cnt_ff - CW'(2));
         S_F_SCAN: rd_addr = scan_more ? AW'(idx_ff - AW'(1)) : AW'(idx_ff + AW'(1));
         default:  rd_addr = '0;
      endcase
   end

   // segment arithmetic
   assign eanc  = anc_hi_ff ? ehi_ff : elo_ff;
   assign tanc  = eanc.t;
   assign dt    = 17'(ehi_ff.t) - 17'(elo_ff.t);
   assign tdiff = 17'(qt_ff) - 17'(tanc);
   assign dvr   = 17'(ehi_ff.r) - 17'(elo_ff.r);
   assign dvs   = $signed({1'b0, ehi_ff.s}) - $signed({1'b0, elo_ff.s});

   // one restoring divide step for both quotients
   assign shr = {rr_ff, nr_ff[PROD_W-1]};
   assign shs = {rs_ff, ns_ff[PROD_W-1]};
   assign trr = shr - {1'b0, den_ff};
   assign trs = shs - {1'b0, den_ff};

   assign qsr  = negr_ff ? -$signed({1'b0, nr_ff}) : $signed({1'b0, nr_ff});
   assign qss  = negs_ff ? -$signed({1'b0, ns_ff}) : $signed({1'b0, ns_ff});
   assign sumr = 36'(eanc.r) + 36'(qsr);
   assign sums = $signed({20'd0, eanc.s}) + 36'(qss);

   assign rerr     = 17'($signed(fr_ff)) - 17'(qr_ff);
   assign rerr_abs = rerr[16] ? 17'(-rerr) : 17'(rerr);
   assign mid      = lo_ff + ((hi_ff - lo_ff) >>> 1);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      prev_t_in    = prev_t_ff;
      prev_r_in    = prev_r_ff;
      upper_in     = upper_ff;
      tol_in       = tol_ff;
      mode_in      = mode_ff;
      qt_in        = qt_ff;
      qr_in        = qr_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      step_in      = step_ff;
      e0_in        = e0_ff;
      el_in        = el_ff;
      elo_in       = elo_ff;
      ehi_in       = ehi_ff;
      idx_in       = idx_ff;
      anc_hi_in    = anc_hi_ff;
      pr_in        = pr_ff;
      ps_in        = ps_ff;
      nr_in        = nr_ff;
      ns_in        = ns_ff;
      rr_in        = rr_ff;
      rs_in        = rs_ff;
      den_in       = den_ff;
      negr_in      = negr_ff;
      negs_in      = negs_ff;
      bit_in       = bit_ff;
      fr_in        = fr_ff;
      fs_in        = fs_ff;
      fst_in       = fst_ff;
      o_rad_in     = o_rad_ff;
      o_res_in     = o_res_ff;
      o_ft_in      = o_ft_ff;
      o_st_in      = o_st_ff;
      o_warn_in    = o_warn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      // register writes, expected only while nothing is in flight
      if (csr_valid) begin
         if (csr_index == CSR_UPPER_TIME) begin
            upper_in = csr_data;
         end else if (csr_index == CSR_TOLERANCE) begin
            tol_in = csr_data[9:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               mode_in   = req_mode;
               qr_in     = req_query_radius;
               qt_in     = req_query_time;
               o_rad_in  = '0;
               o_res_in  = '0;
               o_ft_in   = '0;
               o_st_in   = ST_OK;
               o_warn_in = 1'b0;
               state_in  = S_OUT;
               if (req_mode == MODE_LOAD) begin
                  cnt_in    = load_cnt;
                  prev_t_in = load_prev_t;
                  prev_r_in = load_prev_r;
                  if (load_full) begin
                     o_st_in = ST_FULL;
                  end else begin
                     o_warn_in = (load_prev_r > req_point_radius) ||
                                 (load_prev_t > req_point_time);
                     cnt_in    = load_cnt + CW'(1);
                     prev_t_in = req_point_time;
                     prev_r_in = req_point_radius;
                  end
               end else if (req_mode == MODE_FORWARD || req_mode == MODE_INVERSE) begin
                  if (cnt_ff < CW'(2)) begin
                     o_st_in = ST_TOO_SMALL;
                  end else if (req_mode == MODE_FORWARD) begin
                     state_in = S_F_RD0;
                  end else begin
                     phase_in = PH_LOW;
                     state_in = S_T0_RD;
                  end
               end
            end
         end
         S_T0_RD: begin
            state_in = S_T0_WAIT;
         end
         S_T0_WAIT: begin
            // lower bisection bound is the first table time
            qt_in    = rd_entry.t;
            lo_in    = 18'(rd_entry.t);
            state_in = S_F_RD0;
         end
         S_F_RD0: begin
            state_in = S_F_RDL;
         end
         S_F_RDL: begin
            e0_in    = rd_entry;
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            el_in = rd_entry;
            if (qt_ff < e0_ff.t) begin
               fr_in    = e0_ff.r;
               fs_in    = e0_ff.s;
               fst_in   = ST_CLAMPED;
               state_in = S_EVAL;
            end else if (at_or_above_last) begin
               // last segment, anchored on the last point
               ehi_in    = rd_entry;
               anc_hi_in = 1'b1;
               state_in  = S_F_LO;
            end else begin
               idx_in   = AW'(cnt_ff - CW'(2));
               state_in = S_F_SCAN;
            end
         end
         S_F_SCAN: begin
            if (scan_more) begin
               idx_in = idx_ff - AW'(1);
            end else begin
               elo_in    = rd_entry;
               anc_hi_in = 1'b0;
               state_in  = S_F_HI;
            end
         end
         S_F_HI: begin
            ehi_in   = rd_entry;
            state_in = S_F_MUL;
         end
         S_F_LO: begin
            elo_in   = rd_entry;
            state_in = S_F_MUL;
         end
         S_F_MUL: begin
            if (dt == '0) begin
               fr_in    = eanc.r;
               fs_in    = eanc.s;
               fst_in   = ST_ZERO_SEG;
               state_in = S_EVAL;
            end else begin
               pr_in    = dvr * tdiff;
               ps_in    = dvs * tdiff;
               fst_in   = (anc_hi_ff && (qt_ff > el_ff.t)) ? ST_EXTRAP : ST_OK;
               state_in = S_F_SETUP;
            end
         end
         S_F_SETUP: begin
            nr_in    = pr_ff[PROD_W-1] ? PROD_W'(-pr_ff) : PROD_W'(pr_ff);
            ns_in    = ps_ff[PROD_W-1] ? PROD_W'(-ps_ff) : PROD_W'(ps_ff);
            den_in   = dt[16] ? DEN_W'(-dt) : DEN_W'(dt);
            negr_in  = pr_ff[PROD_W-1] ^ dt[16];
            negs_in  = ps_ff[PROD_W-1] ^ dt[16];
            rr_in    = '0;
            rs_in    = '0;
            bit_in   = '0;
            state_in = S_F_DIV;
         end
         S_F_DIV: begin
            if (!trr[DEN_W]) begin
               rr_in = trr[DEN_W-1:0];
               nr_in = {nr_ff[PROD_W-2:0], 1'b1};
            end else begin
               rr_in = shr[DEN_W-1:0];
               nr_in = {nr_ff[PROD_W-2:0], 1'b0};
            end
            if (!trs[DEN_W]) begin
               rs_in = trs[DEN_W-1:0];
               ns_in = {ns_ff[PROD_W-2:0], 1'b1};
            end else begin
               rs_in = shs[DEN_W-1:0];
               ns_in = {ns_ff[PROD_W-2:0], 1'b0};
            end
            bit_in = bit_ff + BW'(1);
            if (bit_ff == BW'(PROD_W - 1)) begin
               state_in = S_F_FIN;
            end
         end
         S_F_FIN: begin
            fr_in    = sat16(sumr);
            fs_in    = sat16(sums);
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_OUT;
            if (mode_ff == MODE_FORWARD) begin
               o_rad_in = fr_ff;
               o_res_in = fs_ff;
               o_st_in  = fst_ff;
            end else begin
               unique case (phase_ff)
                  PH_LOW: begin
                     if (qr_ff < $signed(fr_ff)) begin
                        o_ft_in = e0_ff.t;
                        o_st_in = ST_CLAMPED;
                     end else begin
                        phase_in = PH_HIGH;
                        qt_in    = {1'b0, upper_ff};
                        state_in = S_F_RD0;
                     end
                  end
                  PH_HIGH: begin
                     if (qr_ff > $signed(fr_ff)) begin
                        o_ft_in = el_ff.t;
                        o_st_in = ST_EXTRAP;
                     end else begin
                        hi_in    = {3'b000, upper_ff};
                        step_in  = '0;
                        phase_in = PH_CHECK;
                        state_in = S_EVAL;
                     end
                  end
                  PH_BISECT: begin
                     if (rerr_abs < {7'd0, tol_ff}) begin
                        o_ft_in = qt_ff;
                        o_st_in = ST_OK;
                     end else begin
                        if (qr_ff > $signed(fr_ff)) begin
                           lo_in = 18'(qt_ff) + 18'sd1;
                        end else begin
                           hi_in = 18'(qt_ff) - 18'sd1;
                        end
                        step_in  = step_ff + SW'(1);
                        phase_in = PH_CHECK;
                        state_in = S_EVAL;
                     end
                  end
                  PH_CHECK: begin
                     // bisection loop test ahead of each step
                     if ((lo_ff <= hi_ff) && (step_ff < SW'(MAX_BISECT_STEPS))) begin
                        qt_in    = mid[15:0];
                        phase_in = PH_BISECT;
                        state_in = S_F_RD0;
                     end else begin
                        o_ft_in = '0;
                        o_st_in = ST_NO_CONV;
                     end
                  end
                  default: begin
                     o_st_in = ST_NO_CONV;
                  end
               endcase
            end
         end
         S_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {o_ft_ff, o_res_ff, o_rad_ff};
               rsp_user_in  = {o_warn_ff, o_st_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_LOW;
         cnt_ff       <= '0;
         prev_t_ff    <= MOST_NEGATIVE;
         prev_r_ff    <= MOST_NEGATIVE;
         upper_ff     <= UPPER_TIME_RESET;
         tol_ff       <= TOLERANCE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         prev_t_ff    <= prev_t_in;
         prev_r_ff    <= prev_r_in;
         upper_ff     <= upper_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      qt_ff       <= qt_in;
      qr_ff       <= qr_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      step_ff     <= step_in;
      e0_ff       <= e0_in;
      el_ff       <= el_in;
      elo_ff      <= elo_in;
      ehi_ff      <= ehi_in;
      idx_ff      <= idx_in;
      anc_hi_ff   <= anc_hi_in;
      pr_ff       <= pr_in;
      ps_ff       <= ps_in;
      nr_ff       <= nr_in;
      ns_ff       <= ns_in;
      rr_ff       <= rr_in;
      rs_ff       <= rs_in;
      den_ff      <= den_in;
      negr_ff     <= negr_in;
      negs_ff     <= negs_in;
      bit_ff      <= bit_in;
      fr_ff       <= fr_in;
      fs_ff       <= fs_in;
      fst_ff      <= fst_in;
      o_rad_ff    <= o_rad_in;
      o_res_ff    <= o_res_in;
      o_ft_ff     <= o_ft_in;
      o_st_ff     <= o_st_in;
      o_warn_ff   <= o_warn_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

### rtl/dttbl_ram.sv
// ----------------------------------------------------------------------------
// dttbl_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dttbl_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dttbl_checker.sv
// ----------------------------------------------------------------------------
// dttbl_checker
// port level checks for the drift time to radius table
// ----------------------------------------------------------------------------
module dttbl_checker
   import dttbl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   // a stalled response keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // order warning only comes with a stored point
   a_warn_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3] |-> rsp_tuser[2:0] == ST_OK)
      else $error("order warning with non-ok status");

   // a failed bisection returns all zero data
   a_noconv_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2:0] == ST_NO_CONV |-> rsp_tdata == '0)
      else $error("non-converged result carries data");

endmodule

bind drift_time_radius_table dttbl_checker u_dttbl_checker (.*);
